// ----- sv/stream_substring_replace_macros.svh -----
// Assertion macros shared by the stream substring replace block
`ifndef STREAM_SUBSTRING_REPLACE_MACROS_SVH
`define STREAM_SUBSTRING_REPLACE_MACROS_SVH

// Check a condition on every clock edge outside reset
`define SSR_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger
`define SSR_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

// ----- sv/ssr_pkg.sv -----
`timescale 1ns / 1ps
// Package with constants and types of the stream substring replace block
package ssr_pkg;

    localparam int PAT_MAX_DEF = 16;
    localparam int REP_MAX_DEF = 32;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int PAT_LEN_W  = 5;
    localparam int REP_LEN_W  = 6;
    localparam int CFG_IDX_W  = 8;

    typedef enum logic [0:0] {
        CMD_DATA  = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH    = 8'd0,
        REG_REPLACE_LENGTH    = 8'd1,
        REG_PATTERN_WORD_LOW  = 8'd2,
        REG_PATTERN_WORD_HIGH = 8'd3,
        REG_REPLACE_WORD_0    = 8'd4,
        REG_REPLACE_WORD_1    = 8'd5,
        REG_REPLACE_WORD_2    = 8'd6,
        REG_REPLACE_WORD_3    = 8'd7
    } t_cfg_reg;

endpackage

// ----- sv/stream_substring_replace.sv -----
`timescale 1ns / 1ps
// Top level of the streaming find-and-replace block
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | in        | i_in_valid / o_in_stall   | i_cmd, i_data_byte
//  out     | out       | o_out_valid / i_out_stall | o_out_byte, o_last
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One input byte per cycle while not stalled. A match emits replace_length
//  results, a full window without a match its oldest byte and a flush one per
//  pending byte, one per cycle while i_out_stall is low; the result sequencer
//  holds the input register meanwhile. Synchronous active-low reset clears the
//  window count, the sequencer, the output valid and the configuration
//  registers; no clearing pass is needed. A stalled output holds its result
//  while one more request waits in the input register.
module stream_substring_replace #(
    parameter int PAT_MAX = ssr_pkg::PAT_MAX_DEF,
    parameter int REP_MAX = ssr_pkg::REP_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [ssr_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ssr_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssr_pkg::WORD_W-1:0]    i_cfg_data
);
    import ssr_pkg::*;

    localparam int CW  = $clog2(PAT_MAX + 1);
    localparam int RCW = $clog2(REP_MAX + 1);
    localparam int RIW = (REP_MAX > 1) ? $clog2(REP_MAX) : 1;

    logic [PAT_LEN_W-1:0] r_pat_len;
    logic [REP_LEN_W-1:0] r_rep_len;
    logic [WORD_W-1:0]    r_pat_lo, r_pat_hi;
    logic [WORD_W-1:0]    r_rep_w0, r_rep_w1, r_rep_w2, r_rep_w3;

    logic                 r_in_valid;
    t_cmd                 r_in_cmd;
    logic [BYTE_W-1:0]    r_in_byte;

    logic [BYTE_W-1:0]    r_win [PAT_MAX];
    logic [CW-1:0]        r_cnt;
    logic [BYTE_W-1:0]    n_win [PAT_MAX];
    logic [CW-1:0]        n_cnt;

    logic                 r_job_active;
    logic                 r_job_flush;
    logic [RCW-1:0]       r_job_idx;

    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_last;

    logic [2*WORD_W-1:0]  pat_all;
    logic [4*WORD_W-1:0]  rep_all;
    logic [BYTE_W-1:0]    pat_bytes [PAT_MAX];
    logic [BYTE_W-1:0]    rep_bytes [REP_MAX];

    logic [PAT_LEN_W-1:0] pl_clip;
    logic [REP_LEN_W-1:0] rl_clip;
    logic [CW-1:0]        eff_pl;
    logic [RCW-1:0]       eff_rl;

    logic [BYTE_W-1:0]    win_app [PAT_MAX];
    logic [BYTE_W-1:0]    win_drop [PAT_MAX];
    logic [BYTE_W-1:0]    win_sh1 [PAT_MAX];
    logic [CW-1:0]        cnt_app;
    logic                 full_cmp;
    logic                 match;
    logic [CW-1:0]        drop_n;

    logic                 is_flush;
    logic                 no_result;
    logic                 out_free;
    logic                 proc;
    logic                 job_step;
    logic [RCW-1:0]       n_job_idx;
    logic                 job_last;
    logic [BYTE_W-1:0]    job_byte;
    logic [BYTE_W-1:0]    first_byte;
    logic                 first_last;
    logic                 first_job;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= PAT_LEN_W'(1);
            r_rep_len <= '0;
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_rep_w0  <= '0;
            r_rep_w1  <= '0;
            r_rep_w2  <= '0;
            r_rep_w3  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PATTERN_LENGTH:    r_pat_len <= i_cfg_data[PAT_LEN_W-1:0];
                REG_REPLACE_LENGTH:    r_rep_len <= i_cfg_data[REP_LEN_W-1:0];
                REG_PATTERN_WORD_LOW:  r_pat_lo  <= i_cfg_data;
                REG_PATTERN_WORD_HIGH: r_pat_hi  <= i_cfg_data;
                REG_REPLACE_WORD_0:    r_rep_w0  <= i_cfg_data;
                REG_REPLACE_WORD_1:    r_rep_w1  <= i_cfg_data;
                REG_REPLACE_WORD_2:    r_rep_w2  <= i_cfg_data;
                REG_REPLACE_WORD_3:    r_rep_w3  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pat_all = {r_pat_hi, r_pat_lo};
    assign rep_all = {r_rep_w3, r_rep_w2, r_rep_w1, r_rep_w0};

    always_comb begin
        for (int i = 0; i < PAT_MAX; i++) begin
            pat_bytes[i] = pat_all[BYTE_W*i +: BYTE_W];
        end
        for (int i = 0; i < REP_MAX; i++) begin
            rep_bytes[i] = rep_all[BYTE_W*i +: BYTE_W];
        end
    end

    // effective lengths
    always_comb begin
        pl_clip = (r_pat_len == '0) ? PAT_LEN_W'(1) : r_pat_len;
        if (pl_clip > PAT_LEN_W'(PAT_MAX)) begin
            pl_clip = PAT_LEN_W'(PAT_MAX);
        end
        rl_clip = (r_rep_len > REP_LEN_W'(REP_MAX)) ? REP_LEN_W'(REP_MAX) : r_rep_len;
        eff_pl  = CW'(pl_clip);
        eff_rl  = RCW'(rl_clip);
    end

    // append, compare, drop
    always_comb begin
        for (int i = 0; i < PAT_MAX; i++) begin
            win_app[i] = r_win[i];
            if (r_cnt == CW'(i)) begin
                win_app[i] = r_in_byte;
            end
        end
        cnt_app = (r_cnt < CW'(PAT_MAX)) ? CW'(r_cnt + 1'b1) : r_cnt;

        full_cmp = (cnt_app >= eff_pl);
        match    = full_cmp;
        for (int i = 0; i < PAT_MAX; i++) begin
            if (CW'(i) < eff_pl && win_app[i] != pat_bytes[i]) begin
                match = 1'b0;
            end
        end

        if (match) begin
            drop_n = eff_pl;
        end else begin
            drop_n = full_cmp ? CW'(1) : '0;
        end

        for (int i = 0; i < PAT_MAX; i++) begin
            win_drop[i] = win_app[i];
            for (int k = 1; i + k < PAT_MAX; k++) begin
                if (drop_n == CW'(k)) begin
                    win_drop[i] = win_app[i + k];
                end
            end
            win_sh1[i] = (i + 1 < PAT_MAX) ? r_win[(i + 1) % PAT_MAX] : r_win[i];
        end
    end

    // request control
    assign is_flush  = (r_in_cmd == CMD_FLUSH);
    assign no_result = is_flush ? (r_cnt == '0) : (!full_cmp || (match && eff_rl == '0));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign proc      = r_in_valid && !r_job_active && (out_free || no_result);
    assign job_step  = r_job_active && out_free;
    assign o_in_stall = r_in_valid && !proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_cmd  <= t_cmd'(i_cmd);
            r_in_byte <= i_data_byte;
        end
    end

    // result sequencer
    assign n_job_idx = RCW'(r_job_idx + 1'b1);
    assign job_last  = r_job_flush ? (r_cnt == CW'(1)) : (n_job_idx == eff_rl);
    assign job_byte  = r_job_flush ? r_win[0] : rep_bytes[r_job_idx[RIW-1:0]];

    always_comb begin
        if (is_flush) begin
            first_byte = r_win[0];
            first_last = (r_cnt == CW'(1));
        end else if (match) begin
            first_byte = rep_bytes[0];
            first_last = (eff_rl == RCW'(1));
        end else begin
            first_byte = win_app[0];
            first_last = 1'b1;
        end
        first_job = !no_result && !first_last;
    end

    // window update
    always_comb begin
        n_win = r_win;
        n_cnt = r_cnt;
        priority if (proc && !is_flush) begin
            n_win = win_drop;
            n_cnt = CW'(cnt_app - drop_n);
        end else if ((proc && is_flush && r_cnt != '0) || (job_step && r_job_flush)) begin
            n_win = win_sh1;
            n_cnt = CW'(r_cnt - 1'b1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_job_active <= 1'b0;
            r_job_flush  <= 1'b0;
            r_job_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (job_step) begin
                r_job_idx <= n_job_idx;
                if (job_last) begin
                    r_job_active <= 1'b0;
                end
            end else if (proc && !no_result) begin
                r_job_active <= first_job;
                r_job_flush  <= is_flush;
                r_job_idx    <= RCW'(1);
            end
            if (out_free) begin
                r_out_valid <= job_step || (proc && !no_result);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_step) begin
            r_out_byte <= job_byte;
            r_out_last <= job_last;
        end else if (proc && !no_result && out_free) begin
            r_out_byte <= first_byte;
            r_out_last <= first_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

    `include "stream_substring_replace_macros.svh"

    `SSR_ASSERT_ALWAYS(a_cnt_below_depth, r_cnt < CW'(PAT_MAX), "window count reached depth")
    `SSR_ASSERT_ALWAYS(a_job_has_output, !r_job_active || r_out_valid, "sequencer active without result")
    `SSR_ASSERT_NEXT(a_flush_empties, job_step && r_job_flush && job_last, r_cnt == '0, "flush left bytes")
    `SSR_ASSERT_NEXT(a_burst_continues, o_out_valid && !i_out_stall && !o_last, o_out_valid, "result burst broken")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the stream substring replace block
module tb;
    import ssr_pkg::*;

    localparam int QUIET_LIMIT    = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 36;
    localparam int PRESSURE_ITEMS = 30;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_NEXT = 8'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP  = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_cmd;
    logic [BYTE_W-1:0]    i_data_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    logic [PAT_LEN_W-1:0] pat_len_q;
    logic [REP_LEN_W-1:0] rep_len_q;
    logic [2*WORD_W-1:0]  pat_bits_q;
    logic [4*WORD_W-1:0]  rep_bits_q;
    logic [BYTE_W-1:0]    window_q [PAT_MAX_DEF];
    int                   window_cnt;

    t_out_beat rewritten_q [$];
    int        mismatch_cnt;
    int        quiet_cycles;
    int        burst_left;
    int        hold_cycles;
    bit        steady;

    stream_substring_replace u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int active_pat_len();
        if (pat_len_q == 0) return 1;
        if (pat_len_q > PAT_MAX_DEF) return PAT_MAX_DEF;
        return int'(pat_len_q);
    endfunction

    task automatic drop_oldest(input int n);
        for (int i = 0; i + n < window_cnt; i++) window_q[i] = window_q[i + n];
        window_cnt -= n;
    endtask

    task automatic rewrite_byte(input t_cmd cmd, input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] emit [$];
        int pl;
        int rl;
        bit hit;
        pl = active_pat_len();
        rl = (rep_len_q > REP_MAX_DEF) ? REP_MAX_DEF : int'(rep_len_q);
        if (cmd == CMD_FLUSH) begin
            for (int i = 0; i < window_cnt; i++) emit.push_back(window_q[i]);
            window_cnt = 0;
        end else begin
            if (window_cnt < PAT_MAX_DEF) begin
                window_q[window_cnt] = data;
                window_cnt++;
            end
            if (window_cnt >= pl) begin
                hit = 1'b1;
                for (int i = 0; i < pl; i++) begin
                    if (window_q[i] != pat_bits_q[8*i +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    for (int i = 0; i < rl; i++) emit.push_back(rep_bits_q[8*i +: 8]);
                    drop_oldest(pl);
                end else begin
                    emit.push_back(window_q[0]);
                    drop_oldest(1);
                end
            end
        end
        foreach (emit[i]) rewritten_q.push_back(t_out_beat'{emit[i], i == emit.size() - 1});
    endtask

    task automatic push_item(input t_cmd cmd, input logic [BYTE_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_cmd       = cmd;
        i_data_byte = data;
        do @(posedge i_clk); while (o_in_stall);
        rewrite_byte(cmd, data);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (rewritten_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_PATTERN_LENGTH:    pat_len_q = val[PAT_LEN_W-1:0];
            REG_REPLACE_LENGTH:    rep_len_q = val[REP_LEN_W-1:0];
            REG_PATTERN_WORD_LOW:  pat_bits_q[WORD_W-1:0] = val;
            REG_PATTERN_WORD_HIGH: pat_bits_q[2*WORD_W-1:WORD_W] = val;
            REG_REPLACE_WORD_0:    rep_bits_q[0*WORD_W +: WORD_W] = val;
            REG_REPLACE_WORD_1:    rep_bits_q[1*WORD_W +: WORD_W] = val;
            REG_REPLACE_WORD_2:    rep_bits_q[2*WORD_W +: WORD_W] = val;
            REG_REPLACE_WORD_3:    rep_bits_q[3*WORD_W +: WORD_W] = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input t_out_beat want);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, what, want.out_byte, want.last, o_out_byte, o_last);
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rewritten_q.size() == 0) begin
                report_mismatch("unexpected result", '0);
            end else begin
                want = rewritten_q.pop_front();
                if (o_out_byte !== want.out_byte || o_last !== want.last)
                    report_mismatch("result mismatch", want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : out_stall_drive
        int stall_mode;
        int mode_left;
        int beat;
        i_out_stall = 1'b0;
        mode_left   = 0;
        stall_mode  = 0;
        beat        = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall = 1'b1;
                hold_cycles--;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(10, 60);
                end
                mode_left--;
                beat++;
                case (stall_mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = 1'($urandom_range(0, 1));
                    2:       i_out_stall = (beat % 4 == 0);
                    default: i_out_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic test_reset_state();
        push_item(CMD_DATA, 8'h00);
        push_item(CMD_DATA, 8'hFF);
        push_item(CMD_FLUSH, 8'($urandom));
        wait_idle();
    endtask

    task automatic test_extremes();
        logic [2*WORD_W-1:0] pat_bits;
        pat_bits = {rand64(), rand64()};
        write_reg(REG_PATTERN_LENGTH, 64'd31);
        write_reg(REG_REPLACE_LENGTH, 64'd63);
        write_reg(REG_PATTERN_WORD_LOW, pat_bits[WORD_W-1:0]);
        write_reg(REG_PATTERN_WORD_HIGH, pat_bits[2*WORD_W-1:WORD_W]);
        write_reg(REG_REPLACE_WORD_0, rand64());
        write_reg(REG_REPLACE_WORD_1, rand64());
        write_reg(REG_REPLACE_WORD_2, rand64());
        write_reg(REG_REPLACE_WORD_3, rand64());
        write_reg(REG_UNUSED_NEXT, '1);
        write_reg(REG_UNUSED_TOP, '1);
        for (int k = 0; k < PAT_MAX_DEF; k++) push_item(CMD_DATA, pat_bits[8*k +: 8]);
        wait_idle();
    endtask

    task automatic test_shrink_pattern();
        logic [WORD_W-1:0] word;
        word = rand64();
        write_reg(REG_PATTERN_LENGTH, 64'd4);
        write_reg(REG_REPLACE_LENGTH, 64'd2);
        write_reg(REG_PATTERN_WORD_LOW, word);
        for (int k = 0; k < 3; k++) push_item(CMD_DATA, word[8*k +: 8]);
        wait_idle();
        // zero length with junk above the field
        write_reg(REG_PATTERN_LENGTH, {~59'd0, 5'd0});
        push_item(CMD_DATA, word[7:0]);
        push_item(CMD_DATA, 8'($urandom));
        push_item(CMD_FLUSH, 8'($urandom));
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        logic [WORD_W-1:0] word;
        word = rand64();
        write_reg(REG_PATTERN_LENGTH, 64'd1);
        write_reg(REG_REPLACE_LENGTH, 64'd3);
        write_reg(REG_PATTERN_WORD_LOW, word);
        write_reg(REG_REPLACE_WORD_0, rand64());
        steady      = 1'b1;
        hold_cycles = HOLD_CYCLES;
        for (int k = 0; k < PRESSURE_ITEMS; k++)
            push_item(CMD_DATA, (k % 2 == 0) ? word[7:0] : 8'($urandom));
        steady = 1'b0;
        push_item(CMD_FLUSH, 8'($urandom));
        wait_idle();
    endtask

    task automatic test_random_streams();
        logic [BYTE_W-1:0]    letters [3];
        logic [2*WORD_W-1:0]  pat_bits;
        logic [WORD_W-1:0]    junk;
        logic [PAT_LEN_W-1:0] pl_raw;
        logic [REP_LEN_W-1:0] rl_raw;
        int sent;
        int phase_end;
        int pl;
        int run;
        bit same;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            foreach (letters[k]) letters[k] = 8'($urandom);
            same = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < PAT_MAX_DEF; k++)
                pat_bits[8*k +: 8] = same ? letters[0] : letters[$urandom_range(0, 2)];
            case ($urandom_range(0, 9))
                0:       pl_raw = '0;
                1:       pl_raw = 5'($urandom_range(17, 31));
                2:       pl_raw = 5'(PAT_MAX_DEF);
                default: pl_raw = 5'($urandom_range(1, 5));
            endcase
            case ($urandom_range(0, 9))
                0:       rl_raw = '0;
                1:       rl_raw = 6'($urandom_range(33, 63));
                2:       rl_raw = 6'(REP_MAX_DEF);
                default: rl_raw = 6'($urandom_range(1, 6));
            endcase
            junk = rand64();
            write_reg(REG_PATTERN_LENGTH, {junk[WORD_W-1:PAT_LEN_W], pl_raw});
            write_reg(REG_REPLACE_LENGTH, {junk[WORD_W-1:REP_LEN_W], rl_raw});
            write_reg(REG_PATTERN_WORD_LOW, pat_bits[WORD_W-1:0]);
            write_reg(REG_PATTERN_WORD_HIGH, pat_bits[2*WORD_W-1:WORD_W]);
            write_reg(REG_REPLACE_WORD_0, rand64());
            write_reg(REG_REPLACE_WORD_1, rand64());
            write_reg(REG_REPLACE_WORD_2, rand64());
            write_reg(REG_REPLACE_WORD_3, rand64());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_NEXT : REG_UNUSED_TOP, rand64());
            pl = active_pat_len();
            phase_end = sent + $urandom_range(8, 24);
            while (sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        for (int k = 0; k < pl; k++) push_item(CMD_DATA, pat_bits[8*k +: 8]);
                        sent += pl;
                    end
                    6: begin
                        run = $urandom_range(1, pl);
                        for (int k = 0; k < run; k++) push_item(CMD_DATA, pat_bits[8*k +: 8]);
                        sent += run;
                    end
                    7: begin
                        run = $urandom_range(1, 5);
                        for (int k = 0; k < run; k++) push_item(CMD_DATA, letters[0]);
                        sent += run;
                    end
                    8: begin
                        push_item(CMD_DATA, letters[$urandom_range(0, 2)]);
                        sent++;
                    end
                    default: begin
                        if ($urandom_range(0, 3) == 0) push_item(CMD_FLUSH, 8'($urandom));
                        else push_item(CMD_DATA, 8'($urandom));
                        sent++;
                    end
                endcase
            end
            // leave the window unflushed now and then so the next setting inherits its bytes
            if ($urandom_range(0, 3) != 0) begin
                push_item(CMD_FLUSH, 8'($urandom));
                sent++;
            end
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_DATA;
        i_data_byte  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        pat_len_q    = 5'd1;
        rep_len_q    = '0;
        pat_bits_q   = '0;
        rep_bits_q   = '0;
        window_cnt   = 0;
        mismatch_cnt = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        hold_cycles  = 0;
        steady       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_extremes();
        test_shrink_pattern();
        test_output_backpressure();
        test_random_streams();
        push_item(CMD_FLUSH, 8'($urandom));
        wait_idle();

        if (mismatch_cnt == 0 && rewritten_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
